// ===== hdl/life_grid_generation_step_macros.svh =====
// Assertion macros shared by the life grid generation step RTL.
// Depends on nothing; included by the top level.
`ifndef LIFE_GRID_GENERATION_STEP_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define LGGS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Implication whose consequent is checked at the next rising edge.
`define LGGS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/lggs_pkg.sv =====
// Package for the life grid generation step: sizes, operation codes and states.
// Depends on nothing.
package lggs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int DIM_W    = 7;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE   = 2'd0;
  localparam op_t OP_READ    = 2'd1;
  localparam op_t OP_ADVANCE = 2'd2;

  typedef logic [MAX_COLS-1:0] row_bits_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_GEN_LOAD,
    ST_GEN_READ,
    ST_GEN_CALC,
    ST_DONE
  } state_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

endpackage

// ===== hdl/life_grid_generation_step.sv =====
// Life grid generation step: one item writes a cell, reads a cell, or advances
// the grid by one generation. The grid is stored one row per RAM word.
// The input channel (in_*) and result channel (out_*) both use valid/ready; every
// accepted transfer yields exactly one result transfer. The grid size comes from
// a plain write port (cfg_we, cfg_index, cfg_data): index 0 rows, 1 columns;
// values beyond 64 are saturated to 64, and zero leaves nothing in use.
// A cell write or read goes from acceptance to a result registered on the
// output by reading the row, then modifying or selecting, then registering. A
// generation reads each row in use once and writes it back, one row at a time
// through the single RAM read port.
// One item is in work at a time; a result held on the output while the receiver
// stalls does not block the next transfer, which is accepted as soon as the
// block is back at rest, but a further result waits until out_ready rises.
// After reset the RAM is swept clear, one row a cycle, and in_ready is low
// meanwhile; configuration writes are taken as always. Reset sets both sizes
// to 64 and drops any pending result.
// Include the shared assertion macros.
`include "life_grid_generation_step_macros.svh"

module life_grid_generation_step (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [5:0] in_row,
  input  logic [5:0] in_col,
  input  logic       in_cell_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_read_value,
  output logic [1:0] out_done_kind,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int AW = lggs_pkg::ROW_AW;
  localparam int DW = lggs_pkg::DIM_W;
  localparam int NC = lggs_pkg::MAX_COLS;

  lggs_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] rows_cfg_r, cols_cfg_r;
  logic [DW-1:0] rows_use, cols_use;

  // Latched item.
  lggs_pkg::op_t op_r;
  logic [5:0]    row_r, col_r;
  logic          val_r;
  logic          res_r, res_nxt;

  // Generation sweep: row counter and the three rows around it.
  logic [AW-1:0]        grow_r, grow_nxt;
  lggs_pkg::row_bits_t  prev_r, prev_nxt, cur_r, cur_nxt;
  lggs_pkg::row_bits_t  below, colmask, new_row;

  logic [AW-1:0] clr_r, clr_nxt;

  logic          out_valid_r;
  logic          out_rv_r;
  lggs_pkg::op_t out_kind_r;

  // RAM port signals.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  lggs_pkg::row_bits_t ram_wdata, ram_rdata;

  logic in_xfer, in_range, last_row;

  lggs_ram #(.WIDTH(NC), .DEPTH(lggs_pkg::MAX_ROWS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rows_use = (rows_cfg_r > DW'(lggs_pkg::MAX_ROWS)) ? DW'(lggs_pkg::MAX_ROWS) : rows_cfg_r;
  assign cols_use = (cols_cfg_r > DW'(lggs_pkg::MAX_COLS)) ? DW'(lggs_pkg::MAX_COLS) : cols_cfg_r;

  assign in_ready = (state_r == lggs_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign in_range = (DW'(row_r) < rows_use) && (DW'(col_r) < cols_use);
  // True when the row in work is the last one in use.
  assign last_row = (DW'(grow_r) + DW'(1)) >= rows_use;

  // Next row below the one in work; rows beyond the size in use count as dead.
  assign below = last_row ? '0 : ram_rdata;

  // New value of every cell of the current row. Columns outside the size in
  // use keep their value and never count as neighbours.
  always_comb begin
    lggs_pkg::row_bits_t pm, cm, nm;
    logic [3:0] cnt;
    for (int c = 0; c < NC; c++) begin
      colmask[c] = (DW'(c) < cols_use);
    end
    pm = prev_r & colmask;
    cm = cur_r & colmask;
    nm = below & colmask;
    for (int c = 0; c < NC; c++) begin
      cnt = {3'd0, pm[c]} + {3'd0, nm[c]};
      if (c > 0) begin
        cnt = cnt + {3'd0, pm[c-1]} + {3'd0, cm[c-1]} + {3'd0, nm[c-1]};
      end
      if (c < NC - 1) begin
        cnt = cnt + {3'd0, pm[c+1]} + {3'd0, cm[c+1]} + {3'd0, nm[c+1]};
      end
      new_row[c] = colmask[c] ? ((cnt == 4'd2) || (cnt == 4'd3)) : cur_r[c];
    end
  end

  always_comb begin
    state_nxt = state_r;
    grow_nxt  = grow_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = row_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = in_row[AW-1:0];
    case (state_r)
      lggs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(lggs_pkg::MAX_ROWS - 1)) begin
          state_nxt = lggs_pkg::ST_IDLE;
        end
      end
      lggs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_nxt  = 1'b0;
          grow_nxt = '0;
          if (in_operation == lggs_pkg::OP_ADVANCE) begin
            ram_raddr = '0;
            state_nxt = (rows_use == '0 || cols_use == '0) ? lggs_pkg::ST_DONE
                                                           : lggs_pkg::ST_GEN_LOAD;
          end else begin
            state_nxt = lggs_pkg::ST_ACCESS;
          end
        end
      end
      lggs_pkg::ST_ACCESS: begin
        // Row data of the addressed cell is on the RAM output now.
        ram_wdata         = ram_rdata;
        ram_wdata[col_r]  = val_r;
        if (op_r == lggs_pkg::OP_WRITE && in_range) begin
          ram_we = 1'b1;
        end
        if (op_r == lggs_pkg::OP_READ && in_range) begin
          res_nxt = ram_rdata[col_r];
        end
        state_nxt = lggs_pkg::ST_DONE;
      end
      lggs_pkg::ST_GEN_LOAD: begin
        cur_nxt   = ram_rdata;
        prev_nxt  = '0;
        state_nxt = lggs_pkg::ST_GEN_READ;
      end
      lggs_pkg::ST_GEN_READ: begin
        ram_raddr = grow_r + AW'(1);
        state_nxt = lggs_pkg::ST_GEN_CALC;
      end
      lggs_pkg::ST_GEN_CALC: begin
        ram_we    = 1'b1;
        ram_waddr = grow_r;
        ram_wdata = new_row;
        prev_nxt  = cur_r;
        cur_nxt   = below;
        grow_nxt  = grow_r + AW'(1);
        state_nxt = last_row ? lggs_pkg::ST_DONE : lggs_pkg::ST_GEN_READ;
      end
      lggs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = lggs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lggs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lggs_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      rows_cfg_r  <= DW'(lggs_pkg::MAX_ROWS);
      cols_cfg_r  <= DW'(lggs_pkg::MAX_COLS);
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        if (cfg_index == lggs_pkg::CFG_ROWS) begin
          rows_cfg_r <= cfg_data;
        end else begin
          cols_cfg_r <= cfg_data;
        end
      end
      if (state_r == lggs_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    grow_r <= grow_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
    if (in_xfer) begin
      op_r  <= in_operation;
      row_r <= in_row;
      col_r <= in_col;
      val_r <= in_cell_value;
    end
    if (state_r == lggs_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_rv_r   <= res_r;
      out_kind_r <= op_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_done_kind  = out_kind_r;

  // The block must not take items while the store is being cleared.
  `LGGS_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, state_r == lggs_pkg::ST_CLEAR, !in_ready, "item accepted during clear")
  // The store is never written while the block rests.
  `LGGS_ASSERT_IMP(a_no_write_idle, clk, rst_n, state_r == lggs_pkg::ST_IDLE, !ram_we, "RAM written while idle")
  // An accepted transfer always starts work.
  `LGGS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_xfer, state_r != lggs_pkg::ST_IDLE, "accepted item left no work")

endmodule

// ===== hdl/lggs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module lggs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
